// ===== src/field_threshold_duration_alarm_top_defines.svh =====
// Assertion macros used by the field threshold duration alarm checker.
`ifndef FIELD_THRESHOLD_DURATION_ALARM_TOP_DEFINES_SVH
`define FIELD_THRESHOLD_DURATION_ALARM_TOP_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is held.
`define FTA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define FTA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fta_pkg.sv =====
// Types and constants of the field threshold duration alarm.
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_DW    = 48;
  localparam int unsigned OUT_DW   = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_AW-1:0] {
    CFG_ALARM_LEVEL       = 2'd0,
    CFG_HYSTERESIS_BAND   = 2'd1,
    CFG_MEDIUM_HOLD_TICKS = 2'd2,
    CFG_LONG_HOLD_TICKS   = 2'd3
  } cfg_idx_t;

  // Reset values of the registers (level 1.0 and band about 0.1 in Q7.8).
  localparam logic [LEVEL_W-1:0] ALARM_LEVEL_RST       = 15'd256;
  localparam logic [LEVEL_W-1:0] HYSTERESIS_BAND_RST   = 15'd26;
  localparam logic [TICK_W-1:0]  MEDIUM_HOLD_TICKS_RST = 32'd98304;
  localparam logic [TICK_W-1:0]  LONG_HOLD_TICKS_RST   = 32'd196608;

  // Largest magnitude, used when the most negative sample is folded.
  localparam logic [LEVEL_W-1:0] MAG_MAX = '1;

  // Current register contents.
  typedef struct packed {
    logic [LEVEL_W-1:0] alarm_level;
    logic [LEVEL_W-1:0] hysteresis_band;
    logic [TICK_W-1:0]  medium_hold_ticks;
    logic [TICK_W-1:0]  long_hold_ticks;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic                       cross_event;
    logic                       alarm_active;
    logic                       medium_event;
    logic                       medium_active;
    logic                       long_event;
    logic                       long_active;
    logic signed [SAMPLE_W-1:0] reported_level;
  } result_t;

endpackage

`default_nettype wire

// ===== src/field_threshold_duration_alarm_top.sv =====
// Top level of the field threshold duration alarm.
// Usage:
//   in_*  : sample beats, tdata = field_sample (signed Q8.8) then now_tick.
//   out_* : one result beat for every sample beat, in the same order.
//   cfg_* : register writes take effect on the edge where cfg_we is high;
//           write them only while no sample is in flight.
// A beat accepted into the input register is decided as it moves into the
// result register, which it enters once the result slot is free or being
// emptied, and shows on out_tvalid from then on.
// Throughput is one beat per cycle while the receiver accepts; the alarm state
// is updated as each beat enters the result register, so the following beat already sees it.
// The limit is the combinational path from the input register through the
// magnitude, band compares and the 32-bit elapsed-time subtract.
// When the receiver stalls, the result holds and the input register keeps
// one more beat; in_tready then drops until out_tready returns.
// Synchronous reset (rst_n low) empties both registers, clears the alarm,
// duration flags and crossing tick, and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module field_threshold_duration_alarm_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // field_sample [15:0], now_tick [47:16]
  input  wire logic [fta_pkg::IN_DW-1:0]     in_tdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // cross_event [0], alarm_active [1], medium_event [2], medium_active [3],
  // long_event [4], long_active [5], reported_level [21:6], zero [23:22]
  output logic [fta_pkg::OUT_DW-1:0]         out_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_we,
  input  wire logic [fta_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [fta_pkg::CFG_DW-1:0]    cfg_wdata
);

  fta_pkg::cfg_t    cfg;
  fta_pkg::result_t res_nxt;
  fta_pkg::result_t res_r;

  logic                                s1_valid_r;
  logic signed [fta_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [fta_pkg::TICK_W-1:0]          s1_tick_r;
  logic                                out_valid_r;
  logic                                advance;

  fta_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The held beat moves on when the result slot is free or being emptied.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[fta_pkg::SAMPLE_W-1:0];
      s1_tick_r   <= in_tdata[fta_pkg::SAMPLE_W +: fta_pkg::TICK_W];
    end
  end

  fta_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .sample  (s1_sample_r),
    .tick    (s1_tick_r),
    .res_nxt (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.reported_level, res_r.long_active, res_r.long_event,
                       res_r.medium_active, res_r.medium_event, res_r.alarm_active,
                       res_r.cross_event};

endmodule

`default_nettype wire

// ===== src/fta_cfg_regs.sv =====
// Configuration registers of the field threshold duration alarm.
`timescale 1ns / 1ps
`default_nettype none

module fta_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [fta_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [fta_pkg::CFG_DW-1:0] cfg_wdata,
  output fta_pkg::cfg_t                  cfg
);

  fta_pkg::cfg_t cfg_r;

  // Writes land at once; each register keeps only its own width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_level       <= fta_pkg::ALARM_LEVEL_RST;
      cfg_r.hysteresis_band   <= fta_pkg::HYSTERESIS_BAND_RST;
      cfg_r.medium_hold_ticks <= fta_pkg::MEDIUM_HOLD_TICKS_RST;
      cfg_r.long_hold_ticks   <= fta_pkg::LONG_HOLD_TICKS_RST;
    end else if (cfg_we) begin
      case (fta_pkg::cfg_idx_t'(cfg_addr))
        fta_pkg::CFG_ALARM_LEVEL: begin
          cfg_r.alarm_level <= cfg_wdata[fta_pkg::LEVEL_W-1:0];
        end
        fta_pkg::CFG_HYSTERESIS_BAND: begin
          cfg_r.hysteresis_band <= cfg_wdata[fta_pkg::LEVEL_W-1:0];
        end
        fta_pkg::CFG_MEDIUM_HOLD_TICKS: begin
          cfg_r.medium_hold_ticks <= cfg_wdata[fta_pkg::TICK_W-1:0];
        end
        fta_pkg::CFG_LONG_HOLD_TICKS: begin
          cfg_r.long_hold_ticks <= cfg_wdata[fta_pkg::TICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/fta_core.sv =====
// Threshold decision and alarm state of the field threshold duration alarm.
`timescale 1ns / 1ps
`default_nettype none

module fta_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fta_pkg::cfg_t                     cfg,
  input  wire logic                              advance,
  input  wire logic signed [fta_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [fta_pkg::TICK_W-1:0]        tick,
  output fta_pkg::result_t                       res_nxt
);

  logic [fta_pkg::TICK_W-1:0] crossing_tick_r, crossing_tick_nxt;
  logic                       above_r, above_nxt;
  logic                       medium_r, medium_nxt;
  logic                       long_r, long_nxt;

  logic [fta_pkg::SAMPLE_W-1:0] neg_sample;
  logic [fta_pkg::LEVEL_W-1:0]  mag;
  logic [fta_pkg::LEVEL_W:0]    upper;
  logic [fta_pkg::LEVEL_W-1:0]  lower;
  logic                         is_above;
  logic                         is_below;
  logic [fta_pkg::TICK_W-1:0]   elapsed;
  logic                         medium_due;
  logic                         long_due;
  logic                         cross_hit;
  logic                         medium_ev;
  logic                         long_ev;

  // Saturating magnitude, the two band edges and the elapsed-time checks.
  always_comb begin
    neg_sample = fta_pkg::SAMPLE_W'(~sample + 16'sd1);
    if (sample == 16'sh8000) begin
      mag = fta_pkg::MAG_MAX;
    end else if (sample[fta_pkg::SAMPLE_W-1]) begin
      mag = neg_sample[fta_pkg::LEVEL_W-1:0];
    end else begin
      mag = sample[fta_pkg::LEVEL_W-1:0];
    end
    upper    = {1'b0, cfg.alarm_level} + {1'b0, cfg.hysteresis_band};
    lower    = cfg.alarm_level - cfg.hysteresis_band;
    is_above = {1'b0, mag} > upper;
    // A band wider than the level puts the lower edge below zero.
    is_below = (cfg.alarm_level > cfg.hysteresis_band) && (mag < lower);
    elapsed    = tick - crossing_tick_r;
    medium_due = elapsed >= cfg.medium_hold_ticks;
    long_due   = elapsed >= cfg.long_hold_ticks;
  end

  // Crossings and hold-time flag changes.
  always_comb begin
    crossing_tick_nxt = crossing_tick_r;
    above_nxt         = above_r;
    medium_nxt        = medium_r;
    long_nxt          = long_r;
    cross_hit         = 1'b0;
    medium_ev         = 1'b0;
    long_ev           = 1'b0;
    if (is_above) begin
      if (!above_r) begin
        // Upward crossing clears both duration flags without an event.
        cross_hit         = 1'b1;
        crossing_tick_nxt = tick;
        above_nxt         = 1'b1;
        medium_nxt        = 1'b0;
        long_nxt          = 1'b0;
      end else begin
        if (medium_due && !medium_r) begin
          medium_nxt = 1'b1;
          medium_ev  = 1'b1;
        end
        if (long_due && !long_r) begin
          long_nxt = 1'b1;
          long_ev  = 1'b1;
        end
      end
    end else if (is_below) begin
      if (above_r) begin
        cross_hit         = 1'b1;
        crossing_tick_nxt = tick;
        above_nxt         = 1'b0;
      end else begin
        if (medium_due && medium_r) begin
          medium_nxt = 1'b0;
          medium_ev  = 1'b1;
        end
        if (long_due && long_r) begin
          long_nxt = 1'b0;
          long_ev  = 1'b1;
        end
      end
    end
    res_nxt.cross_event    = cross_hit;
    res_nxt.alarm_active   = above_nxt;
    res_nxt.medium_event   = medium_ev;
    res_nxt.medium_active  = medium_nxt;
    res_nxt.long_event     = long_ev;
    res_nxt.long_active    = long_nxt;
    res_nxt.reported_level = sample;
  end

  // State moves on whenever the held beat passes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crossing_tick_r <= '0;
      above_r         <= 1'b0;
      medium_r        <= 1'b0;
      long_r          <= 1'b0;
    end else if (advance) begin
      crossing_tick_r <= crossing_tick_nxt;
      above_r         <= above_nxt;
      medium_r        <= medium_nxt;
      long_r          <= long_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/fta_checker.sv =====
// Port-level checks of the field threshold duration alarm, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "field_threshold_duration_alarm_top_defines.svh"

module fta_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic [fta_pkg::IN_DW-1:0]  in_tdata,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic [fta_pkg::OUT_DW-1:0] out_tdata,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic                       cfg_we,
  input wire logic [fta_pkg::CFG_AW-1:0] cfg_addr,
  input wire logic [fta_pkg::CFG_DW-1:0] cfg_wdata
);

  logic cross_ev;
  logic alarm;
  logic med_ev;
  logic med_act;
  logic long_ev;
  logic long_act;
  logic spare_in;

  assign cross_ev = out_tdata[0];
  assign alarm    = out_tdata[1];
  assign med_ev   = out_tdata[2];
  assign med_act  = out_tdata[3];
  assign long_ev  = out_tdata[4];
  assign long_act = out_tdata[5];
  // Inputs the checks do not look at.
  assign spare_in = ^{in_tdata, in_tvalid, in_tready, cfg_we, cfg_addr, cfg_wdata};

  // A stalled result beat keeps its contents.
  `FTA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // A crossing never reports a duration flag change in the same beat.
  `FTA_ASSERT(a_cross_no_flag_ev, clk, rst_n, out_tvalid && cross_ev |-> !med_ev && !long_ev && (spare_in || !spare_in), "flag event together with a crossing")

  // Flags set while above and clear while below, never the other way.
  `FTA_ASSERT(a_flag_dir, clk, rst_n, out_tvalid && (med_ev || long_ev) |-> (!med_ev || med_act == alarm) && (!long_ev || long_act == alarm), "duration flag moved against the alarm side")

  // Reset empties the result slot.
  `FTA_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind field_threshold_duration_alarm_top fta_checker u_fta_checker (.*);

`default_nettype wire
